FILE: rtl/tckh_pkg.sv
`timescale 1ns / 1ps
// Package for the tour canonical key hash block: sizes, hash constants,
// back-end state type and the structs passed between the front, queue and back.
// Depends on nothing.
package tckh_pkg;

   localparam int MaxNodes   = 1024;
   localparam int NodeAw     = $clog2(MaxNodes);
   localparam int CountW     = NodeAw + 1;
   localparam int StoreDepth = 2 * MaxNodes;
   localparam int StoreAw    = NodeAw + 1;
   localparam int NodeW      = 16;
   localparam int HashW      = 64;
   localparam int QueueDepth = 2;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int PhaseW     = 3;

   localparam logic [HashW-1:0] HashSeed = 64'hD6E8FEB86659FD93;
   localparam logic [HashW-1:0] Golden   = 64'h9E3779B97F4A7C15;
   localparam logic [HashW-1:0] GoldenX2 = Golden + Golden;
   localparam logic [HashW-1:0] MixM1    = 64'hBF58476D1CE4E5B9;
   localparam logic [HashW-1:0] MixM2    = 64'h94D049BB133111EB;

   localparam logic [PhaseW-1:0] PhAdd  = 3'd0;
   localparam logic [PhaseW-1:0] PhMul1 = 3'd1;
   localparam logic [PhaseW-1:0] PhSum1 = 3'd2;
   localparam logic [PhaseW-1:0] PhMul2 = 3'd3;
   localparam logic [PhaseW-1:0] PhSum2 = 3'd4;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CMP,
      BK_PREP,
      BK_HASH,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic              bank;
      logic [CountW-1:0] count;
      logic              ovf;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } qpush_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } qhead_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

   typedef struct packed {
      logic               we;
      logic [StoreAw-1:0] addr;
      logic [NodeW-1:0]   data;
   } mem_wr_type;

   typedef struct packed {
      logic [StoreAw-1:0] addr_a;
      logic [StoreAw-1:0] addr_b;
   } mem_rd_type;

endpackage

FILE: rtl/tckh_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces of the tour canonical key hash block:
// request, response and control register write. Depends on tckh_pkg.
interface tckh_req_if
   import tckh_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [NodeW-1:0] node;
   logic             last;

   modport source (output valid, output node, output last, input ready);
   modport sink (input valid, input node, input last, output ready);
endinterface

interface tckh_rsp_if
   import tckh_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [HashW-1:0] hash;
   logic             reversed;
   logic             overflow;

   modport source (output valid, output hash, output reversed, output overflow,
                   input ready);
   modport sink (input valid, input hash, input reversed, input overflow,
                 output ready);
endinterface

interface tckh_csr_if;
   logic valid;
   logic ready;
   logic allow_reverse;

   modport source (output valid, output allow_reverse, input ready);
   modport sink (input valid, input allow_reverse, output ready);
endinterface

FILE: rtl/tckh_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module tckh_ram #(
   parameter int Depth = 2,
   parameter int Width = 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr_a,
   output logic [Width-1:0]         rdata_a,
   input  logic [$clog2(Depth)-1:0] raddr_b,
   output logic [Width-1:0]         rdata_b
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_a_ff;
   logic [Width-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule

FILE: rtl/tckh_front.sv
`timescale 1ns / 1ps
// Front end: accepts tour nodes, writes them into one bank of the tour store
// and queues a job per finished tour. Depends on tckh_pkg and tckh_if.
module tckh_front
   import tckh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tckh_req_if.sink   req,
   input  logic       q_full,
   input  done_type   done,
   output qpush_type  push,
   output mem_wr_type mem_wr
);
   logic [CountW-1:0] count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;
   logic              accept;
   logic              stored;
   logic [CountW-1:0] count_new;
   logic              ovf_new;

   assign req.ready = !busy_ff[bank_ff] && !q_full;
   assign accept    = req.valid && req.ready;
   assign stored    = count_ff < CountW'(MaxNodes);
   assign count_new = count_ff + CountW'(stored);
   assign ovf_new   = ovf_ff || !stored;

   assign mem_wr.we   = accept && stored;
   assign mem_wr.addr = {bank_ff, count_ff[NodeAw-1:0]};
   assign mem_wr.data = req.node;

   assign push.valid     = accept && req.last;
   assign push.job.bank  = bank_ff;
   assign push.job.count = count_new;
   assign push.job.ovf   = ovf_new;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         if (req.last) begin
            count_in         = '0;
            ovf_in           = 1'b0;
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            count_in = count_new;
            ovf_in   = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> busy_ff[done.bank])
      else $error("Back end finished a bank that was not pending.");

   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      mem_wr.we |-> !busy_ff[bank_ff])
      else $error("Store write into a bank that the back end owns.");

   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.job.ovf || push.job.count != '0))
      else $error("Queued a tour with no nodes.");
endmodule

FILE: rtl/tckh_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the back end.
// Depends on tckh_pkg.
module tckh_queue
   import tckh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  qpush_type push,
   input  logic      pop,
   output qhead_type head,
   output logic      full
);
   job_type            entry_ff [QueueDepth];
   logic [QueueAw-1:0] wptr_ff, wptr_in;
   logic [QueueAw-1:0] rptr_ff, rptr_in;
   logic [QueueAw:0]   cnt_ff, cnt_in;

   assign head.valid = cnt_ff != '0;
   assign head.job   = entry_ff[rptr_ff];
   assign full       = cnt_ff == (QueueAw + 1)'(QueueDepth);

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push.valid) begin
         wptr_in = wptr_ff + QueueAw'(1);
      end
      if (pop) begin
         rptr_in = rptr_ff + QueueAw'(1);
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + (QueueAw + 1)'(1);
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - (QueueAw + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wptr_ff] <= push.job;
      end
   end
endmodule

FILE: rtl/tckh_back.sv
`timescale 1ns / 1ps
// Back end: compares forward and reverse forms of a stored tour, runs the
// chained mix hash with a shared multiplier set and holds the response.
// Depends on tckh_pkg and tckh_if.
module tckh_back
   import tckh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             allow_reverse,
   input  qhead_type        head,
   output logic             pop,
   output mem_rd_type       mem_rd,
   input  logic [NodeW-1:0] rd_data_a,
   input  logic [NodeW-1:0] rd_data_b,
   output done_type         done,
   tckh_rsp_if.source       rsp
);
   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic              rev_ff, rev_in;
   logic [CountW-1:0] cidx_ff, cidx_in;
   logic [CountW-1:0] cidx_d_ff, cidx_d_in;
   logic              cv_ff, cv_in;
   logic [CountW-1:0] hidx_ff, hidx_in;
   logic [PhaseW-1:0] phase_ff, phase_in;
   logic              len_pass_ff, len_pass_in;
   logic [HashW-1:0]  h_ff, h_in;
   logic [HashW-1:0]  op_ff, op_in;
   logic [HashW-1:0]  pp_ll_ff, pp_ll_in;
   logic [31:0]       pp_hl_ff, pp_hl_in;
   logic [31:0]       pp_lh_ff, pp_lh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HashW-1:0]  rsp_hash_ff, rsp_hash_in;
   logic              rsp_rev_ff, rsp_rev_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              rsp_free;
   logic              rsp_load;
   logic              cv_issue;
   logic [CountW-1:0] cmp_rev_idx;
   logic [CountW-1:0] hash_rev_idx;
   logic [NodeW-1:0]  cmp_f;
   logic [NodeW-1:0]  cmp_r;
   logic              cmp_hit;
   logic [NodeW-1:0]  node_v;
   logic [HashW-1:0]  x_pre;
   logic [HashW-1:0]  mix_y;
   logic [HashW-1:0]  mul_k;
   logic [HashW-1:0]  prod_ll;
   logic [31:0]       prod_hl;
   logic [31:0]       prod_lh;
   logic [HashW-1:0]  pp_sum;
   logic [HashW-1:0]  pp_mix;
   logic              hidx_end;

   assign rsp_free     = !rsp_valid_ff || rsp.ready;
   assign cv_issue     = cidx_ff < job_ff.count;
   assign cmp_rev_idx  = job_ff.count - cidx_ff;
   assign hash_rev_idx = job_ff.count - hidx_ff;
   assign cmp_f        = rd_data_a;
   assign cmp_r        = (cidx_d_ff == '0) ? '0 : rd_data_b;
   assign cmp_hit      = cv_ff && ((cmp_r != cmp_f) ||
                                   (cidx_d_ff == job_ff.count - CountW'(1)));
   assign hidx_end     = hidx_ff == job_ff.count;

   assign node_v = (rev_ff && hidx_ff == '0) ? '0 : rd_data_a;
   assign x_pre  = len_pass_ff ? HashW'(job_ff.count) + Golden
                               : HashW'(node_v) + GoldenX2 + (h_ff << 6) + (h_ff >> 2);
   assign mix_y  = x_pre ^ (x_pre >> 30);

   assign mul_k   = (phase_ff == PhMul1) ? MixM1 : MixM2;
   assign prod_ll = HashW'(op_ff[31:0]) * HashW'(mul_k[31:0]);
   assign prod_hl = op_ff[63:32] * mul_k[31:0];
   assign prod_lh = op_ff[31:0] * mul_k[63:32];
   assign pp_sum  = pp_ll_ff + {pp_hl_ff + pp_lh_ff, 32'b0};
   assign pp_mix  = (phase_ff == PhSum1) ? (pp_sum ^ (pp_sum >> 27))
                                         : (pp_sum ^ (pp_sum >> 31));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               if (head.job.ovf) begin
                  state_in = BK_OUT;
               end else if (allow_reverse && head.job.count > CountW'(1)) begin
                  state_in = BK_CMP;
               end else begin
                  state_in = BK_PREP;
               end
            end
         end
         BK_CMP: begin
            if (cmp_hit) begin
               state_in = BK_PREP;
            end
         end
         BK_PREP: begin
            state_in = BK_HASH;
         end
         BK_HASH: begin
            if (phase_ff == PhSum2 && len_pass_ff) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (rsp_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = (state_ff == BK_IDLE) && head.valid;
      rsp_load      = (state_ff == BK_OUT) && rsp_free;
      done.valid    = rsp_load;
      done.bank     = job_ff.bank;
      mem_rd.addr_b = {job_ff.bank, cmp_rev_idx[NodeAw-1:0]};
      if (state_ff == BK_CMP) begin
         mem_rd.addr_a = {job_ff.bank, cidx_ff[NodeAw-1:0]};
      end else if (rev_ff) begin
         mem_rd.addr_a = {job_ff.bank, hash_rev_idx[NodeAw-1:0]};
      end else begin
         mem_rd.addr_a = {job_ff.bank, hidx_ff[NodeAw-1:0]};
      end
   end

   always_comb begin
      job_in       = job_ff;
      rev_in       = rev_ff;
      cidx_in      = cidx_ff;
      cidx_d_in    = cidx_d_ff;
      cv_in        = cv_ff;
      hidx_in      = hidx_ff;
      phase_in     = phase_ff;
      len_pass_in  = len_pass_ff;
      h_in         = h_ff;
      op_in        = op_ff;
      pp_ll_in     = pp_ll_ff;
      pp_hl_in     = pp_hl_ff;
      pp_lh_in     = pp_lh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_rev_in   = rsp_rev_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (pop) begin
         job_in  = head.job;
         rev_in  = 1'b0;
         cidx_in = '0;
         cv_in   = 1'b0;
         hidx_in = '0;
      end

      if (state_ff == BK_CMP) begin
         cv_in     = cv_issue;
         cidx_in   = cidx_ff + CountW'(cv_issue);
         cidx_d_in = cidx_ff;
         if (cmp_hit) begin
            rev_in = cmp_r < cmp_f;
         end
      end

      if (state_ff == BK_PREP) begin
         hidx_in     = '0;
         phase_in    = PhAdd;
         len_pass_in = 1'b0;
         h_in        = HashSeed;
      end

      if (state_ff == BK_HASH) begin
         case (phase_ff) inside
            PhAdd: begin
               op_in    = mix_y;
               phase_in = PhMul1;
               if (!len_pass_ff) begin
                  hidx_in = hidx_ff + CountW'(1);
               end
            end
            PhMul1, PhMul2: begin
               pp_ll_in = prod_ll;
               pp_hl_in = prod_hl;
               pp_lh_in = prod_lh;
               phase_in = phase_ff + PhaseW'(1);
            end
            PhSum1: begin
               op_in    = pp_mix;
               phase_in = PhMul2;
            end
            PhSum2: begin
               h_in     = h_ff ^ pp_mix;
               phase_in = PhAdd;
               if (!len_pass_ff && hidx_end) begin
                  len_pass_in = 1'b1;
               end
            end
            default: begin
               phase_in = PhAdd;
            end
         endcase
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = job_ff.ovf ? '0 : h_ff;
         rsp_rev_in   = job_ff.ovf ? 1'b0 : rev_ff;
         rsp_ovf_in   = job_ff.ovf;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rev_ff      <= rev_in;
      cidx_ff     <= cidx_in;
      cidx_d_ff   <= cidx_d_in;
      cv_ff       <= cv_in;
      hidx_ff     <= hidx_in;
      phase_ff    <= phase_in;
      len_pass_ff <= len_pass_in;
      h_ff        <= h_in;
      op_ff       <= op_in;
      pp_ll_ff    <= pp_ll_in;
      pp_hl_ff    <= pp_hl_in;
      pp_lh_ff    <= pp_lh_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.hash     = rsp_hash_ff;
   assign rsp.reversed = rsp_rev_ff;
   assign rsp.overflow = rsp_ovf_ff;

   a_hash_valid_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_HASH) |-> (!job_ff.ovf && job_ff.count != '0))
      else $error("Hashing an empty or overflowed tour.");

   a_cmp_multi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CMP) |-> (job_ff.count > CountW'(1)))
      else $error("Comparing a tour of fewer than two nodes.");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CMP && cv_ff) |-> (cidx_d_ff < job_ff.count))
      else $error("Compare position past the end of the tour.");

   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      done.valid |=> rsp_valid_ff)
      else $error("Finished job did not reach the response register.");
endmodule

FILE: rtl/tour_canonical_key_hash_core.sv
`timescale 1ns / 1ps
// Top level of the tour canonical key hash block: control register, front end,
// job queue, banked tour store and back end. Depends on tckh_pkg, tckh_if,
// tckh_ram, tckh_front, tckh_queue and tckh_back.
//
// Usage. Nodes of a tour arrive on the request channel, one per request, with
// last set on the final node. Each tour yields one response carrying the
// 64-bit hash, the reversed flag and the overflow flag. A tour longer than
// 1024 nodes yields overflow = 1 with hash and reversed at zero. The control
// channel writes allow_reverse; it is always ready. The user must see that it is
// written only while the block is idle; the block itself does not enforce this.
// Flow. The front end takes one node per cycle, while req.ready is high, into
// one of two store banks. After the last node the back end runs the compare
// pass (only with allow_reverse set and more than one node), then the hash loop
// over each node and then the length, which runs one 64-bit mix per item through
// a shared set of 32 x 32 multipliers in add, multiply, sum, multiply and sum
// phases, with the idle, prep and out states as handover.
// Stalls. While the response waits, the back end holds it and the front end
// keeps loading the other bank; requests stall once both banks hold tours.
// Reset clears all control state and allow_reverse; the store needs no clearing.
module tour_canonical_key_hash_core
   import tckh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tckh_req_if.sink    req_if,
   tckh_rsp_if.source  rsp_if,
   tckh_csr_if.sink    csr_if
);
   logic             allow_reverse_ff, allow_reverse_in;
   qpush_type        push;
   qhead_type        head;
   logic             q_full;
   logic             pop;
   done_type         done;
   mem_wr_type       mem_wr;
   mem_rd_type       mem_rd;
   logic [NodeW-1:0] rd_data_a;
   logic [NodeW-1:0] rd_data_b;

   assign csr_if.ready = 1'b1;
   assign allow_reverse_in = (csr_if.valid && csr_if.ready) ? csr_if.allow_reverse
                                                            : allow_reverse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_reverse_ff <= 1'b0;
      end else begin
         allow_reverse_ff <= allow_reverse_in;
      end
   end

   tckh_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .q_full (q_full),
      .done   (done),
      .push   (push),
      .mem_wr (mem_wr)
   );

   tckh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   tckh_ram #(
      .Depth (StoreDepth),
      .Width (NodeW)
   ) u_store (
      .clock   (clock),
      .we      (mem_wr.we),
      .waddr   (mem_wr.addr),
      .wdata   (mem_wr.data),
      .raddr_a (mem_rd.addr_a),
      .rdata_a (rd_data_a),
      .raddr_b (mem_rd.addr_b),
      .rdata_b (rd_data_b)
   );

   tckh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .allow_reverse (allow_reverse_ff),
      .head          (head),
      .pop           (pop),
      .mem_rd        (mem_rd),
      .rd_data_a     (rd_data_a),
      .rd_data_b     (rd_data_b),
      .done          (done),
      .rsp           (rsp_if)
   );
endmodule
